@@ src/sgac_pkg.sv @@
// Shared types, constants and helper functions for the Shift-JIS glyph address core.
// Used by sjis_glyph_address_calc_core and sgac_checker; no other dependencies.
package sgac_pkg;

    // Request: one Shift-JIS byte pair, or two half-width characters.
    typedef struct packed {
        logic [7:0] lead_byte;
        logic [7:0] trail_byte;
    } req_t;

    // Result: the font file offsets for one request.
    typedef struct packed {
        logic        is_half_width;
        logic [1:0]  column_count;
        logic [19:0] first_address;
        logic [14:0] second_address;
    } result_t;

    // Decoded request between the classify stage and the address stage.
    typedef struct packed {
        logic                is_half;
        logic [1:0]          count;
        logic [14:0]         half_first;
        logic [14:0]         half_second;
        logic                fixed;
        logic [11:0]         fixed_addr;
        logic [4:0]          row;
        logic signed [10:0]  lin;
        logic                use164;
        logic signed [17:0]  offset;
    } mid_t;

    localparam logic [11:0] SPACE_FULL = 12'h467;
    localparam logic [11:0] QMARK_FULL = 12'h987;

    localparam logic [1:0] COLS_ONE = 2'd1;
    localparam logic [1:0] COLS_TWO = 2'd2;

    // Kanji rows advance by 31020 bytes (256*165 - 11055 - 165).
    localparam logic [19:0] ROW_STEP = 20'd31020;

    localparam logic signed [17:0] OFS_KANJI_A   = 18'sd87162;
    localparam logic signed [17:0] OFS_KANJI_B   = 18'sd80067;
    localparam logic signed [17:0] OFS_KANJI_EXT = 18'sd95412;

    function automatic logic is_half(input logic [7:0] c);
        return ((c >= 8'h20) && (c <= 8'h7E)) || ((c >= 8'hA1) && (c <= 8'hDF));
    endfunction

    // Three linear segments of the half-width font.
    function automatic logic [14:0] half_addr(input logic [7:0] c);
        logic [14:0] idx;
        logic [14:0] addr;
        if (c <= 8'h63)
        begin
            idx  = 15'(c - 8'h20);
            addr = 15'h1346 + idx * 15'd126;
        end
        else if (c <= 8'h7E)
        begin
            idx  = 15'(c - 8'h64);
            addr = 15'h34BF + idx * 15'd127;
        end
        else
        begin
            idx  = 15'(c - 8'hA1);
            addr = 15'h4226 + idx * 15'd129;
        end
        return addr;
    endfunction

endpackage

@@ src/sjis_glyph_address_calc_core.sv @@
// Shift-JIS glyph address core: byte pair in, half-width or full-width font offsets out.
// Depends on sgac_pkg for the request/result structs, constants and half-width mapping.
//
//   channel   | signals                 | handshake
//   ----------+-------------------------+----------------------------------------
//   request   | start, busy, request    | taken at a clock edge with start & !busy
//   result    | done, result            | valid for one cycle, always taken
//
// One request per clock cycle; busy is never raised.
// Three registers lie between a request and its result: input register, classify register, result register.
// The address stage holds one constant-row multiply and one 11x10 multiply, then a sum.
// Reset clears the valid bits of all three stages; payload registers are not reset.
// The receiver cannot stall, so nothing ever backs up.
module sjis_glyph_address_calc_core
    import sgac_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  req_t    request,
    output logic    done,
    output result_t result
);

    // Stage 0: captured request
    logic    in_valid_reg;
    req_t    in_reg;

    // Stage 1: classified request
    logic    mid_valid_reg;
    mid_t    mid_reg;
    mid_t    mid_next;

    // Stage 2: result
    logic    out_valid_reg;
    result_t out_reg;
    result_t out_next;

    assign busy   = 1'b0;
    assign done   = out_valid_reg;
    assign result = out_reg;

    // Advance the valid bits every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            mid_valid_reg <= in_valid_reg;
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg  <= request;
        mid_reg <= mid_next;
        out_reg <= out_next;
    end

    // Classify: half-width addresses directly, full-width codes by range into
    // row * ROW_STEP + lin * (164 or 165) + offset, or a fixed glyph.
    always_comb
    begin
        logic [15:0] code;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [10:0] lo_rel;

        hi     = in_reg.lead_byte;
        lo     = in_reg.trail_byte;
        code   = {hi, lo};
        lo_rel = 11'({3'b000, lo}) - 11'h09F;

        mid_next             = '0;
        mid_next.is_half     = is_half(hi);
        mid_next.count       = COLS_TWO;
        mid_next.fixed_addr  = SPACE_FULL;

        if (is_half(hi))
        begin
            mid_next.half_first = half_addr(hi);
            if (is_half(lo))
            begin
                mid_next.half_second = half_addr(lo);
            end
            else
            begin
                mid_next.count = COLS_ONE;
            end
        end
        else if ((code >= 16'h8140) && (code <= 16'h83D6))
        begin
            // Symbols, alphanumerics, kana, Greek
            mid_next.use164 = 1'b1;
            mid_next.lin    = 11'(code - 16'h8140);
            if (code <= 16'h817E)       mid_next.offset = 18'sd1127;
            else if (code <= 16'h81AC)  mid_next.offset = 18'sd963;
            else if (code <= 16'h81BF)  mid_next.offset = -18'sd841;
            else if (code <= 16'h81CE)  mid_next.offset = -18'sd2153;
            else if (code <= 16'h81E8)  mid_next.offset = -18'sd3957;
            else if (code <= 16'h81F7)  mid_next.offset = -18'sd5105;
            else if (code == 16'h81FC)  mid_next.offset = -18'sd5761;
            else if (code <= 16'h8258)  mid_next.offset = -18'sd19209;
            else if (code <= 16'h8279)  mid_next.offset = -18'sd20357;
            else if (code <= 16'h829A)  mid_next.offset = -18'sd21505;
            else if (code <= 16'h82F1)  mid_next.offset = -18'sd22161;
            else if (code <= 16'h837E)  mid_next.offset = -18'sd34953;
            else if (code <= 16'h8396)  mid_next.offset = -18'sd35117;
            else if (code <= 16'h83B6)  mid_next.offset = -18'sd36429;
            else if (code >= 16'h83BF)  mid_next.offset = -18'sd37741;
            else                        mid_next.fixed  = 1'b1;
        end
        else if ((code >= 16'h8440) && (code <= 16'h84BE))
        begin
            // Cyrillic and box lines
            mid_next.lin = 11'(code - 16'h8440);
            if (code <= 16'h8460)       mid_next.offset = 18'sd70992;
            else if (code <= 16'h847E)  mid_next.offset = 18'sd68517;
            else if (code <= 16'h8491)  mid_next.offset = 18'sd68352;
            else if (code >= 16'h849F)  mid_next.offset = 18'sd66207;
            else                        mid_next.fixed  = 1'b1;
        end
        else if ((code >= 16'h8740) && (code <= 16'h879E))
        begin
            // Row 13 shows the question mark glyph
            mid_next.fixed      = 1'b1;
            mid_next.fixed_addr = QMARK_FULL;
        end
        else if ((code >= 16'h889F) && (code <= 16'h88FC))
        begin
            mid_next.lin    = 11'(code - 16'h889F);
            mid_next.offset = OFS_KANJI_A;
        end
        else if ((code >= 16'h8940) && (code <= 16'h9872))
        begin
            // Level-1 kanji: low half of the trail range shifts by one cell
            mid_next.fixed  = (lo == 8'h7F);
            mid_next.row    = 5'(hi - 8'h88);
            mid_next.lin    = lo_rel + {10'b0, lo <= 8'h7E};
            mid_next.offset = OFS_KANJI_A;
        end
        else if ((code >= 16'h989F) && (code <= 16'h9FFC))
        begin
            // Level-2 kanji, lower lead bytes
            mid_next.fixed  = (lo == 8'h7F);
            mid_next.row    = 5'(hi - 8'h88);
            mid_next.lin    = lo_rel + {10'b0, lo <= 8'h7E};
            mid_next.offset = OFS_KANJI_B;
        end
        else if ((code >= 16'hE040) && (code <= 16'hEAA4))
        begin
            // Level-2 kanji, upper lead bytes: high half of the trail range drops one cell
            mid_next.fixed  = (lo == 8'h7F);
            mid_next.row    = 5'(hi - 8'hE0);
            mid_next.lin    = lo_rel - {10'b0, lo >= 8'h80};
            mid_next.offset = OFS_KANJI_EXT;
        end
        else
        begin
            mid_next.fixed = 1'b1;
        end
    end

    // Address stage: half-width or fixed address kept, else full-width offset; space glyph if negative.
    always_comb
    begin
        logic        [19:0] prod_row;
        logic signed [9:0]  mult;
        logic signed [20:0] prod_lin;
        logic signed [22:0] sum;

        prod_row = 20'(mid_reg.row) * ROW_STEP;
        mult     = mid_reg.use164 ? 10'sd164 : 10'sd165;
        prod_lin = mid_reg.lin * mult;
        sum      = $signed({3'b000, prod_row}) + 23'(prod_lin) + 23'(mid_reg.offset);

        out_next.is_half_width  = mid_reg.is_half;
        out_next.column_count   = mid_reg.count;
        out_next.second_address = mid_reg.half_second;

        if (mid_reg.is_half)
        begin
            out_next.first_address = {5'b0, mid_reg.half_first};
        end
        else if (mid_reg.fixed)
        begin
            out_next.first_address = {8'b0, mid_reg.fixed_addr};
        end
        else if (sum[22])
        begin
            out_next.first_address = {8'b0, SPACE_FULL};
        end
        else
        begin
            out_next.first_address = sum[19:0];
        end
    end

endmodule

@@ src/sgac_checker.sv @@
// Port-level checker for sjis_glyph_address_calc_core, bound to every instance.
// Depends on sgac_pkg for the result struct and column count constants.
module sgac_port_checker
    import sgac_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    a_one_result_per_request: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("request not answered three cycles later");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without a matching request");

    a_full_width_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.is_half_width) |->
            (result.column_count == COLS_TWO) && (result.second_address == 15'd0))
        else $error("full-width result with bad column count or second address");

    a_half_width_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_half_width) |->
            (result.first_address[19:15] == 5'd0)
            && ((result.column_count == COLS_TWO)
                || ((result.column_count == COLS_ONE) && (result.second_address == 15'd0))))
        else $error("half-width result out of shape");

endmodule

bind sjis_glyph_address_calc_core sgac_port_checker u_sgac_port_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
